### hdl/mtc_quarter_frame_assembler_core_defines.svh
// Assertion macros used by the checker file
`ifndef MTC_QUARTER_FRAME_ASSEMBLER_CORE_DEFINES_SVH
`define MTC_QUARTER_FRAME_ASSEMBLER_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MQFA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mqfa check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define MQFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mqfa check failed");

`endif

### hdl/mqfa_pkg.sv
// Types and constants of the quarter-frame assembler
package mqfa_pkg;

    localparam logic [2:0] PIECE_FRM_LO = 3'd0;
    localparam logic [2:0] PIECE_HRS_HI = 3'd7;

    localparam logic [1:0] FLD_FRM = 2'd0;
    localparam logic [1:0] FLD_SEC = 2'd1;
    localparam logic [1:0] FLD_MIN = 2'd2;
    localparam logic [1:0] FLD_HRS = 2'd3;

    // shown flag bit positions
    localparam int SH_FRM  = 0;
    localparam int SH_SEC  = 1;
    localparam int SH_MIN  = 2;
    localparam int SH_HRS  = 3;
    localparam int SH_RATE = 4;

    localparam logic [4:0] FRAME_LIMIT [4] = '{5'd23, 5'd24, 5'd28, 5'd29};
    localparam logic [5:0] MS_LIMIT  = 6'd59;
    localparam logic [4:0] HRS_LIMIT = 5'd23;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_LOAD,
        OP_FWD,
        OP_REV,
        OP_ERR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] piece;
        logic [3:0] nib;
    } t_cmd;

endpackage

### hdl/mqfa_front.sv
// Front end: accepts quarter-frame bytes and classifies them against the previous piece
module mqfa_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [7:0]     i_s_axis_tdata,   // [6:0] data_byte, [7] zero
    input  logic           i_q_ready,
    output logic           o_push,
    output mqfa_pkg::t_cmd o_cmd
);
    import mqfa_pkg::*;

    logic [2:0] r_prev;
    logic [2:0] n_prev;
    logic [2:0] piece;
    logic [2:0] partner_add;
    logic [2:0] partner_seq;
    t_op        op;

    assign piece       = i_s_axis_tdata[6:4];
    assign partner_add = piece ^ 3'd1;
    assign partner_seq = piece[0] ? piece + 3'd1 : piece - 3'd1;

    always_comb begin
        if (r_prev == partner_add) begin
            op = OP_ADD;
        end else if (r_prev == partner_seq) begin
            if (piece == PIECE_FRM_LO) begin
                op = OP_FWD;
            end else if (piece == PIECE_HRS_HI) begin
                op = OP_REV;
            end else begin
                op = OP_LOAD;
            end
        end else begin
            op = OP_ERR;
        end
    end

    assign o_s_axis_tready = i_q_ready;
    assign o_push          = i_s_axis_tvalid && i_q_ready;
    assign o_cmd           = '{op: op, piece: piece, nib: i_s_axis_tdata[3:0]};
    assign n_prev          = o_push ? piece : r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= PIECE_HRS_HI;
        end else begin
            r_prev <= n_prev;
        end
    end

endmodule

### hdl/mqfa_queue.sv
// Short command queue between front and back end
module mqfa_queue #(
    parameter int DEPTH = 2   // 2 or more
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mqfa_pkg::t_cmd i_cmd,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output mqfa_pkg::t_cmd o_cmd
);
    import mqfa_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL  = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_cnt != FULL);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = do_push ? ((r_wr == LAST) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = do_pop  ? ((r_rd == LAST) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### hdl/mqfa_back.sv
// Back end: applies commands to the time counters and holds the result item
module mqfa_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  mqfa_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    // [4:0] hours, [10:5] minutes, [16:11] seconds, [21:17] frames, [23:22] frame_rate,
    // [24] hours_shown, [25] minutes_shown, [26] seconds_shown, [27] frames_shown,
    // [28] rate_shown, [29] sequence_error, [31:30] zero
    output logic [31:0]    o_m_axis_tdata
);
    import mqfa_pkg::*;

    logic       r_valid;
    logic [4:0] r_frm;
    logic [5:0] r_sec;
    logic [5:0] r_min;
    logic [4:0] r_hrs;
    logic [1:0] r_rate;
    logic [4:0] r_shown;
    logic       r_err;

    logic       n_valid;
    logic [4:0] n_frm;
    logic [5:0] n_sec;
    logic [5:0] n_min;
    logic [4:0] n_hrs;
    logic [1:0] n_rate;
    logic [4:0] n_shown;
    logic       n_err;

    logic [1:0] fld;
    logic [5:0] val;
    logic [5:0] cur;
    logic [5:0] lim;
    logic [6:0] sum;
    logic [5:0] sat;
    logic [5:0] upd;

    assign o_pop = i_q_valid && (!r_valid || i_m_axis_tready);
    assign fld   = i_cmd.piece[2:1];

    always_comb begin
        if (!i_cmd.piece[0]) begin
            val = {2'b00, i_cmd.nib};
        end else if (fld == FLD_SEC || fld == FLD_MIN) begin
            val = {i_cmd.nib[1:0], 4'b0000};
        end else begin
            val = {1'b0, i_cmd.nib[0], 4'b0000};
        end

        case (fld)
            FLD_FRM: begin
                cur = {1'b0, r_frm};
                lim = {1'b0, FRAME_LIMIT[r_rate]};
            end
            FLD_SEC: begin
                cur = r_sec;
                lim = MS_LIMIT;
            end
            FLD_MIN: begin
                cur = r_min;
                lim = MS_LIMIT;
            end
            default: begin
                cur = {1'b0, r_hrs};
                lim = {1'b0, HRS_LIMIT};
            end
        endcase

        sum = {1'b0, cur} + {1'b0, val};
        sat = (sum > {1'b0, lim}) ? lim : sum[5:0];
        upd = (i_cmd.op == OP_ADD) ? sat : val;
    end

    always_comb begin
        n_valid = r_valid;
        n_frm   = r_frm;
        n_sec   = r_sec;
        n_min   = r_min;
        n_hrs   = r_hrs;
        n_rate  = r_rate;
        n_shown = r_shown;
        n_err   = r_err;
        if (o_pop) begin
            n_valid = 1'b1;
            n_err   = 1'b0;
            unique case (i_cmd.op)
                OP_ADD, OP_LOAD: begin
                    case (fld)
                        FLD_FRM: begin
                            n_frm           = upd[4:0];
                            n_shown[SH_FRM] = 1'b1;
                        end
                        FLD_SEC: begin
                            n_sec           = upd;
                            n_shown[SH_SEC] = 1'b1;
                        end
                        FLD_MIN: begin
                            n_min           = upd;
                            n_shown[SH_MIN] = 1'b1;
                        end
                        default: begin
                            n_hrs           = upd[4:0];
                            n_shown[SH_HRS] = 1'b1;
                            // hours high also carries the rate
                            if (i_cmd.piece[0]) begin
                                n_rate           = i_cmd.nib[2:1];
                                n_shown[SH_RATE] = 1'b1;
                            end
                        end
                    endcase
                end
                OP_FWD: begin
                    n_frm            = {1'b0, i_cmd.nib};
                    n_sec            = '0;
                    n_min            = '0;
                    n_hrs            = '0;
                    n_shown          = '0;
                    n_shown[SH_FRM]  = 1'b1;
                    n_shown[SH_RATE] = 1'b1;
                end
                OP_REV: begin
                    n_frm            = '0;
                    n_sec            = '0;
                    n_min            = '0;
                    n_hrs            = {i_cmd.nib[0], 4'b0000};
                    n_rate           = i_cmd.nib[2:1];
                    n_shown          = '0;
                    n_shown[SH_HRS]  = 1'b1;
                    n_shown[SH_RATE] = 1'b1;
                end
                OP_ERR: begin
                    n_sec            = '0;
                    n_min            = '0;
                    n_hrs            = '0;
                    n_shown          = '0;
                    n_shown[SH_RATE] = 1'b1;
                    n_err            = 1'b1;
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end else if (i_m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_frm   <= '0;
            r_sec   <= '0;
            r_min   <= '0;
            r_hrs   <= '0;
            r_rate  <= '0;
            r_shown <= '0;
            r_err   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_frm   <= n_frm;
            r_sec   <= n_sec;
            r_min   <= n_min;
            r_hrs   <= n_hrs;
            r_rate  <= n_rate;
            r_shown <= n_shown;
            r_err   <= n_err;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {2'b00, r_err, r_shown[SH_RATE], r_shown[SH_FRM],
                              r_shown[SH_SEC], r_shown[SH_MIN], r_shown[SH_HRS],
                              r_rate, r_frm, r_sec, r_min, r_hrs};

endmodule

### hdl/mtc_quarter_frame_assembler_core.sv
// Top level of the MIDI time code quarter-frame assembler
// Takes one quarter-frame data byte per item and returns one time result per byte.
// Sustained rate is one item per clock while the result output is not stalled; the command of
// each accepted byte is first written into the queue, and the back end then registers the
// state update, a single saturating add and compare, into its result register.
// The front end classifies each byte against the previous piece and stalls only
// when the queue is full; the back end holds its result until taken and keeps
// draining the queue meanwhile whenever the result register is free or being read.
module mtc_quarter_frame_assembler_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [6:0] data_byte, [7] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [4:0] hours, [10:5] minutes, [16:11] seconds, [21:17] frames, [23:22] frame_rate,
    // [24] hours_shown, [25] minutes_shown, [26] seconds_shown, [27] frames_shown,
    // [28] rate_shown, [29] sequence_error, [31:30] zero
    output logic [31:0] o_m_axis_tdata
);
    import mqfa_pkg::*;

    t_cmd front_cmd;
    t_cmd back_cmd;
    logic push;
    logic q_ready;
    logic q_valid;
    logic pop;

    mqfa_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_ready       (q_ready),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    mqfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (back_cmd)
    );

    mqfa_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (back_cmd),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

### hdl/mqfa_checker.sv
// Port-level checker for the quarter-frame assembler, bound to the top level
`include "mtc_quarter_frame_assembler_core_defines.svh"

module mqfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    // stalled result holds
    `MQFA_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // counts stay within their saturation limits
    `MQFA_ASSERT_NOW(a_range, o_m_axis_tvalid, (o_m_axis_tdata[4:0] <= 5'd23) && (o_m_axis_tdata[10:5] <= 6'd59) && (o_m_axis_tdata[16:11] <= 6'd59) && (o_m_axis_tdata[21:17] <= 5'd29))

    // an out-of-order result blanks the time and clears the upper counts
    `MQFA_ASSERT_NOW(a_err_blank, o_m_axis_tvalid && o_m_axis_tdata[29], (o_m_axis_tdata[28:24] == 5'b10000) && (o_m_axis_tdata[16:0] == 17'd0))

    // padding bits stay zero
    `MQFA_ASSERT_NOW(a_pad, o_m_axis_tvalid, o_m_axis_tdata[31:30] == 2'b00)

    // input stalls only behind a waiting result
    `MQFA_ASSERT_NOW(a_full_stall, !o_s_axis_tready, o_m_axis_tvalid)

endmodule

bind mtc_quarter_frame_assembler_core mqfa_checker u_mqfa_checker (.*);
